// ----- sv/sct_pkg.sv -----
// shared types and constants of the shell command tokenizer
`default_nettype none

package sct_pkg;

    // token kinds carried on the result channel
    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_QUOTED = 2'd1;
    localparam logic [1:0] KIND_OP     = 2'd2;

    // character codes
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    typedef struct packed {
        logic [7:0] tok_byte;
        logic [1:0] tok_kind;
        logic       tok_first;
        logic       tok_last;
        logic       line_done;
        logic       run_last;
    } tok_word_t;

endpackage

`default_nettype wire

// ----- sv/sct_cmd_if.sv -----
// input channel: command line bytes
`default_nettype none

interface sct_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, output ch, output line_end, input ready);
    modport sink (input valid, input ch, input line_end, output ready);
endinterface

`default_nettype wire

// ----- sv/sct_tok_if.sv -----
// result channel: marked token bytes
`default_nettype none

interface sct_tok_if;
    logic       valid;
    logic       ready;
    logic [7:0] tok_byte;
    logic [1:0] tok_kind;
    logic       tok_first;
    logic       tok_last;
    logic       line_done;
    logic       run_last;

    modport source (output valid, output tok_byte, output tok_kind, output tok_first,
                    output tok_last, output line_done, output run_last, input ready);
    modport sink (input valid, input tok_byte, input tok_kind, input tok_first,
                  input tok_last, input line_done, input run_last, output ready);
endinterface

`default_nettype wire

// ----- sv/shell_command_tokenizer_core.sv -----
// shell command line tokenizer: byte stream in, marked token bytes out
//
// usage
//   cmd carries one byte of a command line per word, with line_end set on the
//   line's last byte. tok carries one token byte per word, marked with its
//   kind, first/last flags, line_done and run_last (last word caused by one
//   input byte). blanks and unclassified bytes add no token byte of their own.
// results and throughput
//   each accepted byte is classified in the cycle it is accepted against the
//   held byte and token mode; its zero, one or two result words are written
//   into the 4-entry result queue. one byte is accepted per cycle while the
//   queue has room for two words; the queue drains one word per cycle while
//   tok is ready, so bytes that cause two words (the held byte plus a
//   line-end flush of the new byte) fill it faster than it drains.
// reset
//   rst_n clears the held byte state (nothing held, outside any token) and
//   empties the result queue; the queue payload is not reset.
// stalls
//   when tok is held off the queue fills and cmd.ready drops once fewer than
//   two entries are free; nothing is lost or repeated.
`default_nettype none

module shell_command_tokenizer_core (
    input  wire        clk,
    input  wire        rst_n,
    sct_cmd_if.sink    cmd,
    sct_tok_if.source  tok
);

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_QOPEN   = 3'd2,
        MODE_QCLOSED = 3'd3,
        MODE_OP      = 3'd4,
        MODE_PIPE    = 3'd5,
        MODE_AMP     = 3'd6,
        MODE_SPARE   = 3'd7
    } mode_t;

    // held token byte state
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_first_reg, held_first_next;
    mode_t      mode_reg, mode_next;

    // result queue
    sct_pkg::tok_word_t                fifo_reg [sct_pkg::FIFO_DEPTH];
    logic [sct_pkg::FIFO_AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [sct_pkg::FIFO_AW:0]         count_reg;

    logic       accept;
    logic       pop;
    logic       is_word, is_op, starts, cont;
    mode_t      cont_mode, start_mode, new_mode;
    logic       new_valid, new_first;
    logic       r0_valid, r1_valid;
    sct_pkg::tok_word_t r0, r1, push_a;
    logic [1:0] push_n;

    function automatic logic [1:0] kind_of(input mode_t m);
        logic [1:0] k;
        case (m)
            MODE_WORD:                k = sct_pkg::KIND_WORD;
            MODE_QOPEN, MODE_QCLOSED: k = sct_pkg::KIND_QUOTED;
            default:                  k = sct_pkg::KIND_OP;
        endcase
        return k;
    endfunction

    assign accept = cmd.valid && cmd.ready;
    assign pop    = tok.valid && tok.ready;

    // room for the worst case of two words
    assign cmd.ready = count_reg <= (sct_pkg::FIFO_AW+1)'(sct_pkg::FIFO_DEPTH - 2);

    // byte classes
    always_comb
    begin
        is_word = (cmd.ch inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                                  sct_pkg::CH_DOT, sct_pkg::CH_DASH, sct_pkg::CH_SLASH,
                                  sct_pkg::CH_UNDER, sct_pkg::CH_DOLLAR, sct_pkg::CH_QUOTE});
        is_op   = (cmd.ch inside {sct_pkg::CH_LT, sct_pkg::CH_GT, sct_pkg::CH_PIPE,
                                  sct_pkg::CH_AMP, sct_pkg::CH_SEMI, sct_pkg::CH_EQ});
        starts  = is_word || is_op;
    end

    // does the new byte extend the held token
    always_comb
    begin
        cont      = 1'b0;
        cont_mode = mode_reg;
        if (held_valid_reg)
        begin
            case (mode_reg)
                MODE_WORD:
                begin
                    cont = is_word;
                end
                MODE_QOPEN:
                begin
                    cont = is_word || (cmd.ch == sct_pkg::CH_SPACE);
                    if (cmd.ch == sct_pkg::CH_QUOTE)
                    begin
                        cont_mode = MODE_QCLOSED;
                    end
                end
                MODE_PIPE:
                begin
                    cont      = (cmd.ch == sct_pkg::CH_PIPE);
                    cont_mode = MODE_OP;
                end
                MODE_AMP:
                begin
                    cont      = (cmd.ch == sct_pkg::CH_AMP);
                    cont_mode = MODE_OP;
                end
                default:
                begin
                    cont = 1'b0;
                end
            endcase
        end
    end

    // mode of a token opened by this byte
    always_comb
    begin
        if (!starts)
        begin
            start_mode = MODE_NONE;
        end
        else if (cmd.ch == sct_pkg::CH_PIPE)
        begin
            start_mode = MODE_PIPE;
        end
        else if (cmd.ch == sct_pkg::CH_AMP)
        begin
            start_mode = MODE_AMP;
        end
        else if (is_op)
        begin
            start_mode = MODE_OP;
        end
        else if (cmd.ch == sct_pkg::CH_QUOTE)
        begin
            start_mode = MODE_QOPEN;
        end
        else
        begin
            start_mode = MODE_WORD;
        end
    end

    // results and next state
    always_comb
    begin
        new_valid = cont || starts;
        new_first = !cont;
        new_mode  = cont ? cont_mode : start_mode;

        // held byte goes out whenever something is held
        r0_valid     = held_valid_reg;
        r0.tok_byte  = held_byte_reg;
        r0.tok_kind  = kind_of(mode_reg);
        r0.tok_first = held_first_reg;
        r0.tok_last  = !cont;
        r0.line_done = !cont && cmd.line_end && !starts;

        // line end flushes the byte just taken in
        r1_valid     = cmd.line_end && new_valid;
        r1.tok_byte  = cmd.ch;
        r1.tok_kind  = kind_of(new_mode);
        r1.tok_first = new_first;
        r1.tok_last  = 1'b1;
        r1.line_done = 1'b1;
        r1.run_last  = 1'b1;
        r0.run_last  = !r1_valid;

        push_a = r0_valid ? r0 : r1;
        push_n = accept ? (2'(r0_valid) + 2'(r1_valid)) : 2'd0;

        held_byte_next = new_valid ? cmd.ch : held_byte_reg;
        if (r1_valid)
        begin
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
            mode_next       = MODE_NONE;
        end
        else
        begin
            held_valid_next = new_valid;
            held_first_next = new_valid ? new_first : held_first_reg;
            mode_next       = new_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_byte_reg  <= 8'd0;
            held_first_reg <= 1'b0;
            mode_reg       <= MODE_NONE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                held_valid_reg <= held_valid_next;
                held_byte_reg  <= held_byte_next;
                held_first_reg <= held_first_next;
                mode_reg       <= mode_next;
            end
            wr_ptr_reg <= wr_ptr_reg + sct_pkg::FIFO_AW'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (sct_pkg::FIFO_AW+1)'(push_n)
                         - (sct_pkg::FIFO_AW+1)'(pop);
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 1'b1] <= r1;
        end
    end

    assign tok.valid     = count_reg != '0;
    assign tok.tok_byte  = fifo_reg[rd_ptr_reg].tok_byte;
    assign tok.tok_kind  = fifo_reg[rd_ptr_reg].tok_kind;
    assign tok.tok_first = fifo_reg[rd_ptr_reg].tok_first;
    assign tok.tok_last  = fifo_reg[rd_ptr_reg].tok_last;
    assign tok.line_done = fifo_reg[rd_ptr_reg].line_done;
    assign tok.run_last  = fifo_reg[rd_ptr_reg].run_last;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (sct_pkg::FIFO_AW+1)'(sct_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_idle_mode: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid_reg |-> (mode_reg == MODE_NONE))
        else $error("token mode set with nothing held");

    a_line_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.line_end) |=> !held_valid_reg)
        else $error("byte still held after line end");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == (sct_pkg::FIFO_AW+1)'(sct_pkg::FIFO_DEPTH))
        |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking testbench for the shell command tokenizer core
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // stall limit: cycles in a row with no word moving on either side
    localparam int unsigned IDLE_LIMIT = 2000;
    // cycles watched after the last expected word, receiver always ready
    localparam int unsigned TAIL_CYCLES = 20;
    // rough stimulus size, counted in input words
    localparam int unsigned RANDOM_WORDS = 1350;

    // blank characters outside the package set
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // lexer states of the predictor, same meaning as the block's token modes
    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_WORD,
        LEX_QUOTE_OPEN,
        LEX_QUOTE_SHUT,
        LEX_OPER,
        LEX_PIPE,
        LEX_AMP
    } lex_state_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } cmd_word_t;

    logic clk = 1'b0;
    logic rst_n;

    sct_cmd_if cmd_bus ();
    sct_tok_if tok_bus ();

    shell_command_tokenizer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .tok   (tok_bus)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // bytes still to be sent and token words the block owes us
    cmd_word_t           byte_queue[$];
    sct_pkg::tok_word_t  token_queue[$];

    // predictor state: the byte held back until its successor decides it
    logic       lex_held;
    logic [7:0] lex_byte;
    logic       lex_first;
    lex_state_t lex_state;

    int unsigned fail_count = 0;
    logic        tail_phase = 1'b0;

    string word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-/_$";

    // ------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------
    function automatic logic is_oper_char(input logic [7:0] c);
        return c == sct_pkg::CH_LT || c == sct_pkg::CH_GT || c == sct_pkg::CH_PIPE
            || c == sct_pkg::CH_AMP || c == sct_pkg::CH_SEMI || c == sct_pkg::CH_EQ;
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
            return 1'b1;
        return c == sct_pkg::CH_DOT || c == sct_pkg::CH_DASH || c == sct_pkg::CH_SLASH
            || c == sct_pkg::CH_UNDER || c == sct_pkg::CH_DOLLAR || c == sct_pkg::CH_QUOTE;
    endfunction

    // token word for the held byte, kind taken from the current lexer state
    function automatic sct_pkg::tok_word_t held_word(input logic last, input logic done);
        sct_pkg::tok_word_t w;
        w.tok_byte  = lex_byte;
        case (lex_state)
            LEX_WORD:                       w.tok_kind = sct_pkg::KIND_WORD;
            LEX_QUOTE_OPEN, LEX_QUOTE_SHUT: w.tok_kind = sct_pkg::KIND_QUOTED;
            default:                        w.tok_kind = sct_pkg::KIND_OP;
        endcase
        w.tok_first = lex_first;
        w.tok_last  = last;
        w.line_done = done;
        w.run_last  = 1'b0;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // predictor: one accepted byte in, zero to two token words queued
    // ------------------------------------------------------------------
    function automatic void lex_step(input logic [7:0] c, input logic eol);
        sct_pkg::tok_word_t made[$];
        logic       joins;
        logic       opens;
        lex_state_t follow;
        joins  = 1'b0;
        follow = lex_state;

        // does the new byte extend the token of the held byte
        if (lex_held)
        begin
            case (lex_state)
                LEX_WORD:
                    joins = is_word_char(c);
                LEX_QUOTE_OPEN:
                begin
                    joins = is_word_char(c) || c == sct_pkg::CH_SPACE;
                    if (c == sct_pkg::CH_QUOTE)
                        follow = LEX_QUOTE_SHUT;
                end
                LEX_PIPE:
                begin
                    joins  = (c == sct_pkg::CH_PIPE);
                    follow = LEX_OPER;
                end
                LEX_AMP:
                begin
                    joins  = (c == sct_pkg::CH_AMP);
                    follow = LEX_OPER;
                end
                default:
                    joins = 1'b0;
            endcase
        end

        if (joins)
        begin
            made.push_back(held_word(1'b0, 1'b0));
            lex_byte  = c;
            lex_first = 1'b0;
            lex_state = follow;
        end
        else
        begin
            // held byte closes its token; line_done only if nothing new starts
            opens = is_oper_char(c) || is_word_char(c);
            if (lex_held)
                made.push_back(held_word(1'b1, eol && !opens));
            lex_held  = 1'b0;
            lex_state = LEX_IDLE;
            if (opens)
            begin
                lex_held  = 1'b1;
                lex_byte  = c;
                lex_first = 1'b1;
                if (c == sct_pkg::CH_PIPE)
                    lex_state = LEX_PIPE;
                else if (c == sct_pkg::CH_AMP)
                    lex_state = LEX_AMP;
                else if (is_oper_char(c))
                    lex_state = LEX_OPER;
                else if (c == sct_pkg::CH_QUOTE)
                    lex_state = LEX_QUOTE_OPEN;
                else
                    lex_state = LEX_WORD;
            end
        end

        // end of line flushes whatever is still held
        if (eol && lex_held)
        begin
            made.push_back(held_word(1'b1, 1'b1));
            lex_held  = 1'b0;
            lex_first = 1'b0;
            lex_state = LEX_IDLE;
        end

        if (made.size() != 0)
            made[made.size() - 1].run_last = 1'b1;
        foreach (made[i])
            token_queue.push_back(made[i]);
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] c, input logic eol);
        cmd_word_t w;
        w.ch       = c;
        w.line_end = eol;
        byte_queue.push_back(w);
    endfunction

    function automatic void add_line(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1);
    endfunction

    function automatic logic [7:0] pick_word_char();
        return word_set[$urandom_range(0, word_set.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_oper_char();
        case ($urandom_range(0, 5))
            0:       return sct_pkg::CH_LT;
            1:       return sct_pkg::CH_GT;
            2:       return sct_pkg::CH_PIPE;
            3:       return sct_pkg::CH_AMP;
            4:       return sct_pkg::CH_SEMI;
            default: return sct_pkg::CH_EQ;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        if ($urandom_range(0, 2) != 0)
            return sct_pkg::CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    // one random command line: mostly well formed tokens, some noise
    function automatic void add_random_line();
        logic [7:0] line[$];
        logic [7:0] op;
        int         tokens;
        int         len;
        int         pick;

        if ($urandom_range(0, 29) == 0)
        begin
            // pure noise line, any byte value
            len = $urandom_range(1, 10);
            repeat (len)
                line.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            tokens = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0)
                line.push_back(pick_blank());
            repeat (tokens)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    // plain word, now and then with a quote inside
                    len = $urandom_range(1, 8);
                    line.push_back(pick_word_char());
                    repeat (len - 1)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            line.push_back(sct_pkg::CH_QUOTE);
                        else
                            line.push_back(pick_word_char());
                    end
                end
                else if (pick < 55)
                begin
                    // quoted word with spaces, usually closed
                    len = $urandom_range(0, 6);
                    line.push_back(sct_pkg::CH_QUOTE);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            line.push_back(sct_pkg::CH_SPACE);
                        else
                            line.push_back(pick_word_char());
                    end
                    if ($urandom_range(0, 4) != 0)
                        line.push_back(sct_pkg::CH_QUOTE);
                end
                else if (pick < 85)
                begin
                    // operator, single or a run of pipes or ampersands
                    op = pick_oper_char();
                    line.push_back(op);
                    if ((op == sct_pkg::CH_PIPE || op == sct_pkg::CH_AMP)
                        && $urandom_range(0, 1) == 1)
                    begin
                        line.push_back(op);
                        if ($urandom_range(0, 3) == 0)
                            line.push_back(op);
                    end
                end
                else
                begin
                    line.push_back(8'($urandom_range(0, 255)));
                end

                // separator: blanks, nothing, or an unclassified byte
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    repeat ($urandom_range(1, 2))
                        line.push_back(pick_blank());
                end
                else if (pick == 9)
                begin
                    if ($urandom_range(0, 1) == 1)
                        line.push_back(8'($urandom_range(128, 255)));
                    else
                        line.push_back(8'($urandom_range(0, 8)));
                end
            end
            // a line always carries at least the byte with line_end
            if (line.size() == 0)
                line.push_back(pick_blank());
        end

        foreach (line[i])
            push_byte(line[i], i == line.size() - 1);
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of bytes with random gaps between them
    // ------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;
    cmd_word_t   next_byte;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid    <= 1'b0;
            cmd_bus.ch       <= '0;
            cmd_bus.line_end <= 1'b0;
            burst_left       <= 0;
            gap_left         <= 0;
        end
        else
        begin
            // the byte that just went in feeds the predictor
            if (cmd_bus.valid && cmd_bus.ready)
                lex_step(cmd_bus.ch, cmd_bus.line_end);

            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (gap_left != 0)
                begin
                    cmd_bus.valid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end
                else if (byte_queue.size() != 0)
                begin
                    next_byte        = byte_queue.pop_front();
                    cmd_bus.valid    <= 1'b1;
                    cmd_bus.ch       <= next_byte.ch;
                    cmd_bus.line_end <= next_byte.line_end;
                    // end of burst: pick the next gap (often none) and burst length
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each token word, stalls on its own pattern
    // ------------------------------------------------------------------
    sct_pkg::tok_word_t seen_word;
    sct_pkg::tok_word_t owed_word;
    logic [1:0]  stall_mode;
    int unsigned stall_left;
    int unsigned tick;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_bus.ready <= 1'b0;
            stall_mode    <= 2'd0;
            stall_left    <= 0;
            tick          <= 0;
        end
        else
        begin
            if (tok_bus.valid && tok_bus.ready)
            begin
                seen_word.tok_byte  = tok_bus.tok_byte;
                seen_word.tok_kind  = tok_bus.tok_kind;
                seen_word.tok_first = tok_bus.tok_first;
                seen_word.tok_last  = tok_bus.tok_last;
                seen_word.line_done = tok_bus.line_done;
                seen_word.run_last  = tok_bus.run_last;
                if (token_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: token word with none owed: byte %h kind %0d",
                                  " first %b last %b done %b run_last %b"},
                                 $realtime, seen_word.tok_byte, seen_word.tok_kind,
                                 seen_word.tok_first, seen_word.tok_last,
                                 seen_word.line_done, seen_word.run_last);
                end
                else
                begin
                    owed_word = token_queue.pop_front();
                    if (seen_word.tok_byte !== owed_word.tok_byte
                        || seen_word.tok_kind !== owed_word.tok_kind
                        || seen_word.tok_first !== owed_word.tok_first
                        || seen_word.tok_last !== owed_word.tok_last
                        || seen_word.line_done !== owed_word.line_done
                        || seen_word.run_last !== owed_word.run_last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: token word mismatch", $realtime);
                            $display({"  expected byte %h kind %0d first %b",
                                      " last %b done %b run_last %b"},
                                     owed_word.tok_byte, owed_word.tok_kind,
                                     owed_word.tok_first, owed_word.tok_last,
                                     owed_word.line_done, owed_word.run_last);
                            $display({"  actual   byte %h kind %0d first %b",
                                      " last %b done %b run_last %b"},
                                     seen_word.tok_byte, seen_word.tok_kind,
                                     seen_word.tok_first, seen_word.tok_last,
                                     seen_word.line_done, seen_word.run_last);
                        end
                    end
                end
            end

            // stall pattern: always ready, mostly ready, mostly stalled, periodic
            tick <= tick + 1;
            if (stall_left == 0)
            begin
                stall_mode <= 2'($urandom_range(0, 3));
                stall_left <= $urandom_range(20, 200);
            end
            else
            begin
                stall_left <= stall_left - 1;
            end

            if (tail_phase)
                tok_bus.ready <= 1'b1;
            else
            begin
                case (stall_mode)
                    2'd0:    tok_bus.ready <= 1'b1;
                    2'd1:    tok_bus.ready <= ($urandom_range(0, 3) != 0);
                    2'd2:    tok_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: tok_bus.ready <= ((tick % 8) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no word moving on either channel
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (tok_bus.valid && tok_bus.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, stimulus, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        lex_held  = 1'b0;
        lex_byte  = '0;
        lex_first = 1'b0;
        lex_state = LEX_IDLE;

        // directed lines
        // empty line of unclassified bytes, both ends of the byte range
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFF, 1'b1);
        // single operators other than pipe and ampersand, line end on a held operator gives two words
        add_line("<>;=");
        // triple pipe and triple ampersand
        add_line("|||&&&");
        // quote inside a plain word, with letter and digit extremes
        add_line("z\"A9");
        // closed quoted word with a space, then a word right after it
        add_line("\"a b\"_");
        // quoted word broken by an operator
        add_line("\"Z<");
        // unclosed quote at line end
        add_line("\"x");
        // pipe and ampersand must not pair across lines
        add_line("|");
        add_line("|");
        add_line("&");

        while (byte_queue.size() < RANDOM_WORDS)
            add_random_line();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // everything sent, then everything received
        while (byte_queue.size() != 0 || cmd_bus.valid)
            @(posedge clk);
        while (token_queue.size() != 0)
            @(posedge clk);

        // watch for stray words with the receiver wide open
        tail_phase = 1'b1;
        repeat (TAIL_CYCLES) @(posedge clk);

        // every owed word must have shown up
        if (fail_count == 0 && token_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/sct_pkg.sv
sv/sct_cmd_if.sv
sv/sct_tok_if.sv
sv/shell_command_tokenizer_core.sv
bench/tb_top.sv
